@@ hw/rtl/irpd_pkg.sv @@
// Package for the IR pulse distance decoder: types, register codes, reset values.
// Used by every module of the decoder; depends on nothing.
package irpd_pkg;

    // Build-time defaults
    localparam int CODE_BYTES_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Bytes of code that the result carries
    localparam int STORE_BYTES = 4;

    // Field widths
    localparam int TICK_W  = 8;
    localparam int IVAL_W  = 7;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 8;
    localparam int CODE_W  = 8 * STORE_BYTES;

    // Counter tops (saturation)
    localparam logic [TICK_W-1:0] TICK_TOP = '1;
    localparam logic [IVAL_W-1:0] IVAL_TOP = '1;

    // Register reset values
    localparam logic [7:0] HEADER_MIN_RST  = 8'd120;
    localparam logic [7:0] REPEAT_LOW_RST  = 8'd105;
    localparam logic [7:0] REPEAT_HIGH_RST = 8'd115;
    localparam logic [7:0] ZERO_MAX_RST    = 8'd14;
    localparam logic [7:0] ONE_LIMIT_RST   = 8'd28;
    localparam logic [7:0] TIMEOUT_RST     = 8'd200;
    localparam logic [6:0] MAX_IVAL_RST    = 7'd80;

    // Register indexes on the configuration channel
    typedef enum logic [ADDR_W-1:0] {
        CFG_HEADER_MIN  = 3'd0,
        CFG_REPEAT_LOW  = 3'd1,
        CFG_REPEAT_HIGH = 3'd2,
        CFG_ZERO_MAX    = 3'd3,
        CFG_ONE_LIMIT   = 3'd4,
        CFG_TIMEOUT     = 3'd5,
        CFG_MAX_IVAL    = 3'd6
    } cfg_addr_t;

    // Capture phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CAPTURE = 2'd1
    } phase_t;

    // Frame class set by the first interval
    typedef enum logic [1:0] {
        FC_UNKNOWN = 2'd0,
        FC_DATA    = 2'd1,
        FC_REPEAT  = 2'd2,
        FC_OTHER   = 2'd3
    } frame_class_t;

    // Classified operation passed from front to back
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_FALL = 1'b1
    } op_t;

    // Input action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_PIN  = 1'b1;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPEAT = 1'b1;

    // Live configuration
    typedef struct packed {
        logic [7:0] header_min;
        logic [7:0] repeat_low;
        logic [7:0] repeat_high;
        logic [7:0] zero_max;
        logic [7:0] one_limit;
        logic [7:0] timeout;
        logic [6:0] max_ival;
    } cfg_t;

    // Front to queue push
    typedef struct packed {
        logic push;
        op_t  op;
    } push_t;

endpackage

@@ hw/rtl/irpd_if.sv @@
// Handshake channel interfaces of the IR pulse distance decoder.
// Depends on irpd_pkg for field widths.

// Input events: ticks and pin changes
interface irpd_in_if;
    logic valid;
    logic ready;
    logic action;
    logic level;
    modport source (output valid, output action, output level, input ready);
    modport sink   (input valid, input action, input level, output ready);
endinterface

// Decoded results
interface irpd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [7:0] byte_fourth;
    modport source (output valid, output kind, output byte_first, output byte_second,
                    output byte_third, output byte_fourth, input ready);
    modport sink   (input valid, input kind, input byte_first, input byte_second,
                    input byte_third, input byte_fourth, output ready);
endinterface

// Register writes
interface irpd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [irpd_pkg::ADDR_W-1:0]  addr;
    logic [irpd_pkg::DATA_W-1:0]  wdata;
    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

@@ hw/rtl/irpd_cfg_regs.sv @@
// Configuration register file of the IR pulse distance decoder.
// Depends on irpd_pkg and irpd_cfg_if.
module irpd_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    irpd_cfg_if.sink           cfg_ch,
    output irpd_pkg::cfg_t     cfg
);

    irpd_pkg::cfg_t cfg_reg;
    irpd_pkg::cfg_t cfg_next;

    assign cfg_ch.ready = 1'b1;
    assign cfg          = cfg_reg;

    // Decode the write index; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            case (irpd_pkg::cfg_addr_t'(cfg_ch.addr))
                irpd_pkg::CFG_HEADER_MIN:  cfg_next.header_min  = cfg_ch.wdata;
                irpd_pkg::CFG_REPEAT_LOW:  cfg_next.repeat_low  = cfg_ch.wdata;
                irpd_pkg::CFG_REPEAT_HIGH: cfg_next.repeat_high = cfg_ch.wdata;
                irpd_pkg::CFG_ZERO_MAX:    cfg_next.zero_max    = cfg_ch.wdata;
                irpd_pkg::CFG_ONE_LIMIT:   cfg_next.one_limit   = cfg_ch.wdata;
                irpd_pkg::CFG_TIMEOUT:     cfg_next.timeout     = cfg_ch.wdata;
                irpd_pkg::CFG_MAX_IVAL:    cfg_next.max_ival    = cfg_ch.wdata[6:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_min  <= irpd_pkg::HEADER_MIN_RST;
            cfg_reg.repeat_low  <= irpd_pkg::REPEAT_LOW_RST;
            cfg_reg.repeat_high <= irpd_pkg::REPEAT_HIGH_RST;
            cfg_reg.zero_max    <= irpd_pkg::ZERO_MAX_RST;
            cfg_reg.one_limit   <= irpd_pkg::ONE_LIMIT_RST;
            cfg_reg.timeout     <= irpd_pkg::TIMEOUT_RST;
            cfg_reg.max_ival    <= irpd_pkg::MAX_IVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/irpd_front.sv @@
// Front end of the IR pulse distance decoder: accepts items and classifies them.
// Depends on irpd_pkg and irpd_in_if.
module irpd_front (
    irpd_in_if.sink            in_ch,
    input  logic               q_ready,
    output irpd_pkg::push_t    push
);

    logic accept;

    // Accept whenever the queue has room
    assign in_ch.ready = q_ready;
    assign accept      = in_ch.valid && q_ready;

    // Ticks and falling edges go on; rising edges are dropped here
    always_comb
    begin
        push.push = 1'b0;
        push.op   = irpd_pkg::OP_TICK;
        if (accept)
        begin
            if (in_ch.action == irpd_pkg::ACT_TICK)
            begin
                push.push = 1'b1;
                push.op   = irpd_pkg::OP_TICK;
            end
            else if (!in_ch.level)
            begin
                push.push = 1'b1;
                push.op   = irpd_pkg::OP_FALL;
            end
        end
    end

endmodule

@@ hw/rtl/irpd_queue.sv @@
// Short FIFO of classified operations between front and back end.
// Depends on irpd_pkg.
module irpd_queue #(
    parameter int DEPTH = irpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  irpd_pkg::push_t    push,
    output logic               q_ready,
    output logic               q_valid,
    output irpd_pkg::op_t      q_op,
    input  logic               pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    irpd_pkg::op_t   slot_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign q_ready = (cnt_reg != CW'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_op    = slot_reg[rd_reg];
    assign do_push = push.push && q_ready;
    assign do_pop  = pop && q_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push.op;
        end
    end

endmodule

@@ hw/rtl/irpd_back.sv @@
// Back end of the IR pulse distance decoder: capture state, bit assembly, result register.
// Depends on irpd_pkg and irpd_out_if.
module irpd_back #(
    parameter int CODE_BYTES = irpd_pkg::CODE_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  irpd_pkg::cfg_t     cfg,
    input  logic               q_valid,
    input  irpd_pkg::op_t      q_op,
    output logic               pop,
    irpd_out_if.source         out_ch
);

    localparam int BDW = $clog2(CODE_BYTES + 1);
    localparam logic [BDW-1:0] BD_FULL = BDW'(CODE_BYTES);

    irpd_pkg::phase_t               phase_reg, phase_next;
    irpd_pkg::frame_class_t         class_reg, class_next;
    logic [irpd_pkg::TICK_W-1:0]    tick_reg, tick_next;
    logic [irpd_pkg::IVAL_W-1:0]    ival_reg, ival_next;
    logic [7:0]                     sbyte_reg, sbyte_next;
    logic [2:0]                     bib_reg, bib_next;
    logic [BDW-1:0]                 bd_reg, bd_next;
    logic [irpd_pkg::CODE_W-1:0]    code_reg, code_next;
    logic                           oval_reg, oval_next;
    logic                           okind_reg, okind_next;
    logic [irpd_pkg::CODE_W-1:0]    ocode_reg, ocode_next;

    logic                           go;
    logic                           finish;
    logic                           emit;
    logic                           bit_ok;
    logic                           bit_val;
    logic [7:0]                     shifted;
    logic [3:0]                     bd_wide;

    // Work on the next operation when the result slot is free or draining
    assign go  = q_valid && (!oval_reg || out_ch.ready);
    assign pop = go;

    assign shifted = {sbyte_reg[6:0], bit_val};
    assign bd_wide = 4'(bd_reg);

    // Sort a bit interval into zero, one or skip
    always_comb
    begin
        bit_ok  = 1'b0;
        bit_val = 1'b0;
        if ((tick_reg != '0) && (tick_reg <= cfg.zero_max))
        begin
            bit_ok = 1'b1;
        end
        else if ((tick_reg > cfg.zero_max) && (tick_reg < cfg.one_limit))
        begin
            bit_ok  = 1'b1;
            bit_val = 1'b1;
        end
    end

    // Next state, capture end and result
    always_comb
    begin
        phase_next = phase_reg;
        class_next = class_reg;
        tick_next  = tick_reg;
        ival_next  = ival_reg;
        sbyte_next = sbyte_reg;
        bib_next   = bib_reg;
        bd_next    = bd_reg;
        code_next  = code_reg;
        finish     = 1'b0;
        emit       = 1'b0;

        if (go)
        begin
            case (q_op)
                irpd_pkg::OP_TICK:
                begin
                    if (phase_reg == irpd_pkg::PH_CAPTURE)
                    begin
                        tick_next = (tick_reg == irpd_pkg::TICK_TOP) ? tick_reg
                                                                      : tick_reg + 1'b1;
                        finish    = (tick_next > cfg.timeout);
                    end
                end
                irpd_pkg::OP_FALL:
                begin
                    if (phase_reg != irpd_pkg::PH_CAPTURE)
                    begin
                        phase_next = irpd_pkg::PH_CAPTURE;
                        tick_next  = '0;
                        ival_next  = '0;
                        class_next = irpd_pkg::FC_UNKNOWN;
                        sbyte_next = '0;
                        bib_next   = '0;
                        bd_next    = '0;
                    end
                    else
                    begin
                        // First interval classes the frame
                        if (ival_reg == '0)
                        begin
                            if (tick_reg > cfg.header_min)
                            begin
                                class_next = irpd_pkg::FC_DATA;
                            end
                            else if ((tick_reg > cfg.repeat_low) &&
                                     (tick_reg < cfg.repeat_high))
                            begin
                                class_next = irpd_pkg::FC_REPEAT;
                            end
                            else
                            begin
                                class_next = irpd_pkg::FC_OTHER;
                            end
                        end
                        else if ((class_reg == irpd_pkg::FC_DATA) && bit_ok &&
                                 (bd_reg < BD_FULL))
                        begin
                            // MSB-first bit assembly; a full byte is stored at once
                            if (bib_reg == 3'd7)
                            begin
                                if (bd_wide < 4'(irpd_pkg::STORE_BYTES))
                                begin
                                    code_next[8*bd_wide[1:0] +: 8] = shifted;
                                end
                                bd_next    = bd_reg + 1'b1;
                                bib_next   = '0;
                                sbyte_next = '0;
                            end
                            else
                            begin
                                sbyte_next = shifted;
                                bib_next   = bib_reg + 1'b1;
                            end
                        end
                        tick_next = '0;
                        ival_next = (ival_reg == irpd_pkg::IVAL_TOP) ? ival_reg
                                                                      : ival_reg + 1'b1;
                        finish    = (ival_next > cfg.max_ival);
                    end
                end
                default:
                begin
                    finish = 1'b0;
                end
            endcase
        end

        if (finish)
        begin
            phase_next = irpd_pkg::PH_IDLE;
            emit = ((class_next == irpd_pkg::FC_DATA) && (bd_next >= BD_FULL)) ||
                   (class_next == irpd_pkg::FC_REPEAT);
        end
    end

    // Result register
    always_comb
    begin
        oval_next  = oval_reg;
        okind_next = okind_reg;
        ocode_next = ocode_reg;
        if (emit)
        begin
            oval_next  = 1'b1;
            okind_next = (class_next == irpd_pkg::FC_REPEAT) ? irpd_pkg::KIND_REPEAT
                                                              : irpd_pkg::KIND_DATA;
            ocode_next = code_next;
        end
        else if (out_ch.ready)
        begin
            oval_next = 1'b0;
        end
    end

    assign out_ch.valid       = oval_reg;
    assign out_ch.kind        = okind_reg;
    assign out_ch.byte_first  = ocode_reg[7:0];
    assign out_ch.byte_second = ocode_reg[15:8];
    assign out_ch.byte_third  = ocode_reg[23:16];
    assign out_ch.byte_fourth = ocode_reg[31:24];

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= irpd_pkg::PH_IDLE;
            class_reg <= irpd_pkg::FC_UNKNOWN;
            tick_reg  <= '0;
            ival_reg  <= '0;
            sbyte_reg <= '0;
            bib_reg   <= '0;
            bd_reg    <= '0;
            code_reg  <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            tick_reg  <= tick_next;
            ival_reg  <= ival_next;
            sbyte_reg <= sbyte_next;
            bib_reg   <= bib_next;
            bd_reg    <= bd_next;
            code_reg  <= code_next;
            oval_reg  <= oval_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        okind_reg <= okind_next;
        ocode_reg <= ocode_next;
    end

    // A falling edge while idle opens a capture
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (go && (q_op == irpd_pkg::OP_FALL) && (phase_reg == irpd_pkg::PH_IDLE))
        |=> (phase_reg == irpd_pkg::PH_CAPTURE))
        else $error("falling edge in idle did not start capture");

    // A result is only loaded at capture end
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == irpd_pkg::PH_IDLE) && oval_reg)
        else $error("result loaded without ending capture");

    // Once all bytes are in, no partial byte is being built
    a_bits_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (bd_reg >= BD_FULL) |-> (bib_reg == '0))
        else $error("bits taken after the code was complete");

    // Idle ticks leave the tick counter alone
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == irpd_pkg::PH_IDLE) && !(go && (q_op == irpd_pkg::OP_FALL)))
        |=> $stable(tick_reg))
        else $error("tick counter moved while idle");

endmodule

@@ hw/rtl/ir_pulse_distance_decoder.sv @@
// IR pulse distance decoder top level. The item that ends a capture is held in the queue,
// then the back end loads the result register from it; a result still waiting stalls this.
// Throughput: 1 item per cycle while the result slot is free or draining; a QUEUE_DEPTH
// queue lets the input keep flowing while a result waits, until the queue is full.
// Reset (rst_n, async, low): registers to defaults, idle, code store zero, queue empty.
module ir_pulse_distance_decoder #(
    parameter int CODE_BYTES  = irpd_pkg::CODE_BYTES_DEF,
    parameter int QUEUE_DEPTH = irpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    irpd_in_if.sink      in_ch,
    irpd_out_if.source   out_ch,
    irpd_cfg_if.sink     cfg_ch
);

    irpd_pkg::cfg_t   cfg;
    irpd_pkg::push_t  push;
    irpd_pkg::op_t    q_op;
    logic             q_ready;
    logic             q_valid;
    logic             pop;

    // Register file
    irpd_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    // Item intake and classification
    irpd_front u_front (
        .in_ch   (in_ch),
        .q_ready (q_ready),
        .push    (push)
    );

    // Decoupling queue
    irpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .q_ready (q_ready),
        .q_valid (q_valid),
        .q_op    (q_op),
        .pop     (pop)
    );

    // Capture and decode
    irpd_back #(
        .CODE_BYTES (CODE_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_op    (q_op),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

@@ tb/irpd_frame_checker.sv @@
`timescale 1ns / 100ps
// Checker for the IR pulse distance decoder: watches the input, result and register channels,
// predicts each decoded frame and compares it with what the block delivers.
// Depends on irpd_pkg and the channel interfaces in irpd_if.sv.
module irpd_frame_checker (
    input  logic clk,
    input  logic rst_n,
    irpd_in_if   in_mon,
    irpd_out_if  out_mon,
    irpd_cfg_if  cfg_mon,
    output int   fail_count,
    output int   pending
);
    import irpd_pkg::*;

    localparam int CODE_BYTES = CODE_BYTES_DEF;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [7:0] byte_third;
        logic [7:0] byte_fourth;
    } frame_result_t;

    // Shadow of the live registers
    cfg_t          regs;

    // Decoder state
    phase_t        phase;
    logic [7:0]    ticks;
    logic [6:0]    ivals;
    frame_class_t  fclass;
    logic [7:0]    shreg;
    int            nbits;
    int            nbytes;
    logic [31:0]   code;

    frame_result_t due_frames[$];
    int            errs;

    // End of capture: data frames need all code bytes, repeats always report
    task automatic close_frame();
        frame_result_t r;
        if ((fclass == FC_DATA && nbytes >= CODE_BYTES) || fclass == FC_REPEAT) begin
            r.kind        = (fclass == FC_REPEAT) ? KIND_REPEAT : KIND_DATA;
            r.byte_first  = code[7:0];
            r.byte_second = code[15:8];
            r.byte_third  = code[23:16];
            r.byte_fourth = code[31:24];
            due_frames.push_back(r);
        end
        phase = PH_IDLE;
    endtask

    // MSB-first shift; each finished byte lands in the code store at once
    task automatic shift_in(input logic bitv);
        if (nbytes >= CODE_BYTES)
            return;
        shreg = {shreg[6:0], bitv};
        nbits++;
        if (nbits >= 8) begin
            if (nbytes < STORE_BYTES)
                code[nbytes*8 +: 8] = shreg;
            nbytes++;
            nbits = 0;
            shreg = '0;
        end
    endtask

    // First interval classes the frame, later ones are bits of a data frame
    task automatic sort_interval(input logic [7:0] len);
        if (ivals == '0) begin
            if (len > regs.header_min)
                fclass = FC_DATA;
            else if (len > regs.repeat_low && len < regs.repeat_high)
                fclass = FC_REPEAT;
            else
                fclass = FC_OTHER;
        end
        else if (fclass == FC_DATA) begin
            if (len > 0 && len <= regs.zero_max)
                shift_in(1'b0);
            else if (len > regs.zero_max && len < regs.one_limit)
                shift_in(1'b1);
        end
    endtask

    task automatic decode_item(input logic act, input logic lvl);
        if (act == ACT_TICK) begin
            if (phase == PH_CAPTURE) begin
                if (ticks != TICK_TOP)
                    ticks++;
                if (ticks > regs.timeout)
                    close_frame();
            end
        end
        else if (lvl == 1'b0) begin
            if (phase != PH_CAPTURE) begin
                phase  = PH_CAPTURE;
                ticks  = '0;
                ivals  = '0;
                fclass = FC_UNKNOWN;
                shreg  = '0;
                nbits  = 0;
                nbytes = 0;
            end
            else begin
                sort_interval(ticks);
                ticks = '0;
                if (ivals != IVAL_TOP)
                    ivals++;
                if (ivals > regs.max_ival)
                    close_frame();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t got;
        frame_result_t want;
        if (!rst_n) begin
            regs.header_min  = HEADER_MIN_RST;
            regs.repeat_low  = REPEAT_LOW_RST;
            regs.repeat_high = REPEAT_HIGH_RST;
            regs.zero_max    = ZERO_MAX_RST;
            regs.one_limit   = ONE_LIMIT_RST;
            regs.timeout     = TIMEOUT_RST;
            regs.max_ival    = MAX_IVAL_RST;
            phase  = PH_IDLE;
            ticks  = '0;
            ivals  = '0;
            fclass = FC_UNKNOWN;
            shreg  = '0;
            nbits  = 0;
            nbytes = 0;
            code   = '0;
            errs   = 0;
            due_frames.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            // Delivered frame against the oldest prediction
            if (out_mon.valid && out_mon.ready) begin
                got.kind        = out_mon.kind;
                got.byte_first  = out_mon.byte_first;
                got.byte_second = out_mon.byte_second;
                got.byte_third  = out_mon.byte_third;
                got.byte_fourth = out_mon.byte_fourth;
                if (due_frames.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d bytes=%h %h %h %h", $time,
                             got.kind, got.byte_first, got.byte_second, got.byte_third,
                             got.byte_fourth);
                    errs++;
                end
                else begin
                    want = due_frames.pop_front();
                    if (got.kind !== want.kind || got.byte_first !== want.byte_first ||
                        got.byte_second !== want.byte_second ||
                        got.byte_third !== want.byte_third ||
                        got.byte_fourth !== want.byte_fourth) begin
                        $display("%0t: result mismatch exp kind=%0d bytes=%h %h %h %h",
                                 $time, want.kind, want.byte_first, want.byte_second,
                                 want.byte_third, want.byte_fourth);
                        $display("%0t:                 act kind=%0d bytes=%h %h %h %h",
                                 $time, got.kind, got.byte_first, got.byte_second,
                                 got.byte_third, got.byte_fourth);
                        errs++;
                    end
                end
            end

            // Register write
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_addr_t'(cfg_mon.addr))
                    CFG_HEADER_MIN:  regs.header_min  = cfg_mon.wdata;
                    CFG_REPEAT_LOW:  regs.repeat_low  = cfg_mon.wdata;
                    CFG_REPEAT_HIGH: regs.repeat_high = cfg_mon.wdata;
                    CFG_ZERO_MAX:    regs.zero_max    = cfg_mon.wdata;
                    CFG_ONE_LIMIT:   regs.one_limit   = cfg_mon.wdata;
                    CFG_TIMEOUT:     regs.timeout     = cfg_mon.wdata;
                    CFG_MAX_IVAL:    regs.max_ival    = cfg_mon.wdata[6:0];
                    default: ;
                endcase
            end

            // Input item
            if (in_mon.valid && in_mon.ready)
                decode_item(in_mon.action, in_mon.level);

            fail_count <= errs;
            pending    <= due_frames.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the IR pulse distance decoder testbench: clock, reset, frame stimulus, result
// back-pressure and the verdict. Depends on irpd_pkg, irpd_if.sv and irpd_frame_checker.
module tb_top;
    import irpd_pkg::*;

    localparam logic [ADDR_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum int {
        FORM_DATA,
        FORM_REPEAT,
        FORM_OTHER
    } frame_form_t;

    logic clk;
    logic rst_n;
    logic hold_req;

    irpd_in_if  in_ch();
    irpd_out_if out_ch();
    irpd_cfg_if cfg_ch();

    int fail_count;
    int pending;

    // Register values as last written
    logic [7:0] hdr_min, rep_lo, rep_hi, zero_max, one_lim, tmo;
    logic [6:0] ival_max;

    int sent_items;
    int good_frames;
    int send_idle_pct;
    int recv_idle_pct;

    ir_pulse_distance_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    irpd_frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .cfg_mon    (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls plus one long hold-off on request
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int min_of(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // One item on the input channel; idle pattern follows the item count
    task automatic push_item(input logic act, input logic lvl);
        if (sent_items < 1600) begin
            send_idle_pct = 6;
            recv_idle_pct = 49;
        end
        else if (sent_items < 3000) begin
            send_idle_pct = 49;
            recv_idle_pct = 6;
        end
        else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.level  <= lvl;
        do @(posedge clk); while (!in_ch.ready);
        if (!(act == ACT_PIN && lvl == 1'b1))
            sent_items++;
    endtask

    // A run of ticks, with optional rising edges mixed in
    task automatic tick_run(input int n, input bit noisy);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(7) == 0)
                push_item(ACT_PIN, 1'b1);
            push_item(ACT_TICK, 1'($urandom_range(1)));
        end
    endtask

    task automatic fall();
        push_item(ACT_PIN, 1'b0);
    endtask

    // Wait until every predicted frame is out and the pipeline has emptied
    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.wdata <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Write the whole register set from the mirror, block idle
    task automatic apply_cfg();
        drain();
        write_reg(CFG_HEADER_MIN,  hdr_min);
        write_reg(CFG_REPEAT_LOW,  rep_lo);
        write_reg(CFG_REPEAT_HIGH, rep_hi);
        write_reg(CFG_ZERO_MAX,    zero_max);
        write_reg(CFG_ONE_LIMIT,   one_lim);
        write_reg(CFG_TIMEOUT,     tmo);
        write_reg(CFG_MAX_IVAL,    {1'($urandom_range(1)), ival_max});
        if ($urandom_range(3) == 0)
            write_reg(CFG_UNUSED, 8'($urandom));
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Small timings so that frames stay short
    task automatic pick_profile();
        int z, o, rl, rh, hm, to;
        z  = $urandom_range(3, 1);
        o  = z + 2 + $urandom_range(2);
        rl = $urandom_range(4);
        rh = rl + 2 + $urandom_range(3);
        hm = rh - 1 + $urandom_range(3);
        to = ((hm > o) ? hm : o) + 1 + $urandom_range(5);
        zero_max = 8'(z);
        one_lim  = 8'(o);
        rep_lo   = 8'(rl);
        rep_hi   = 8'(rh);
        hdr_min  = 8'(hm);
        tmo      = 8'(to);
        ival_max = ($urandom_range(9) < 7) ? 7'($urandom_range(126, 33))
                                           : 7'($urandom_range(32, 1));
    endtask

    // Falling edge, first interval, bit intervals, then timeout to end capture
    task automatic send_frame(input frame_form_t form, input int nbits,
                              input logic [63:0] bits_v, input bit noisy);
        int hl, len;
        fall();
        case (form)
            FORM_DATA:   hl = $urandom_range(int'(tmo), int'(hdr_min) + 1);
            FORM_REPEAT: hl = $urandom_range(min_of(min_of(int'(rep_hi) - 1, int'(hdr_min)),
                                                    int'(tmo)), int'(rep_lo) + 1);
            default:     hl = $urandom_range(min_of(min_of(int'(rep_lo), int'(hdr_min)),
                                                    int'(tmo)), 0);
        endcase
        tick_run(hl, noisy);
        fall();
        for (int i = 0; i < nbits; i++) begin
            // interval that sorts as neither bit
            if (noisy && $urandom_range(15) == 0) begin
                if ($urandom_range(1) == 0 || one_lim > tmo)
                    len = 0;
                else
                    len = $urandom_range(int'(tmo), int'(one_lim));
                tick_run(len, noisy);
                fall();
            end
            if (bits_v[i % 64])
                len = $urandom_range(int'(one_lim) - 1, int'(zero_max) + 1);
            else
                len = $urandom_range(int'(zero_max), 1);
            tick_run(len, noisy);
            fall();
        end
        tick_run(int'(tmo) + 1, noisy);
    endtask

    // Random items, then a timeout run so the block ends idle
    task automatic send_noise(input int n);
        repeat (n) push_item(1'($urandom_range(1)), 1'($urandom_range(1)));
        tick_run(int'(tmo) + 1, 1'b0);
    endtask

    // One frame drawn from the random mix
    task automatic send_mixed();
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            send_frame(FORM_DATA, 32, {$urandom, $urandom}, $urandom_range(3) == 0);
            good_frames++;
        end
        else if (r < 55) begin
            if ($urandom_range(1) == 0)
                send_frame(FORM_DATA, $urandom_range(45, 33), {$urandom, $urandom}, 1'b1);
            else
                send_frame(FORM_DATA, $urandom_range(31, 1), {$urandom, $urandom}, 1'b1);
        end
        else if (r < 80) begin
            send_frame(FORM_REPEAT, 0, '0, $urandom_range(1) == 0);
            good_frames++;
        end
        else if (r < 90)
            send_frame(FORM_OTHER, $urandom_range(10), {$urandom, $urandom}, 1'b1);
        else
            send_noise($urandom_range(30, 10));
    endtask

    initial
    begin
        in_ch.valid  <= 1'b0;
        in_ch.action <= ACT_TICK;
        in_ch.level  <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.addr  <= CFG_HEADER_MIN;
        cfg_ch.wdata <= '0;
        hold_req     <= 1'b0;
        rst_n        <= 1'b0;
        sent_items    = 0;
        good_frames   = 0;
        send_idle_pct = 6;
        recv_idle_pct = 49;
        hdr_min  = HEADER_MIN_RST;
        rep_lo   = REPEAT_LOW_RST;
        rep_hi   = REPEAT_HIGH_RST;
        zero_max = ZERO_MAX_RST;
        one_lim  = ONE_LIMIT_RST;
        tmo      = TIMEOUT_RST;
        ival_max = MAX_IVAL_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored items while idle, start, rising edge in capture, empty intervals
        push_item(ACT_TICK, 1'b0);
        push_item(ACT_TICK, 1'b1);
        push_item(ACT_PIN, 1'b1);
        fall();
        push_item(ACT_TICK, 1'b1);
        push_item(ACT_PIN, 1'b1);
        fall();
        fall();
        tick_run(3, 1'b0);
        fall();
        tick_run(int'(tmo) + 1, 1'b0);

        // Default timings: one repeat code, one full data frame
        send_frame(FORM_REPEAT, 0, '0, 1'b0);
        send_frame(FORM_DATA, 32, {$urandom, $urandom}, 1'b1);

        // Low extremes: zero thresholds, zero timeout, shortest interval limit
        hdr_min  = 8'd0;
        rep_lo   = 8'd0;
        rep_hi   = 8'd0;
        zero_max = 8'd0;
        one_lim  = 8'd0;
        tmo      = 8'd0;
        ival_max = 7'd1;
        apply_cfg();
        send_noise(40);

        // High extremes: the timeout is crossed only as the tick counter reaches its top
        hdr_min  = 8'd255;
        rep_lo   = 8'd0;
        rep_hi   = 8'd255;
        zero_max = 8'd255;
        one_lim  = 8'd255;
        tmo      = 8'd254;
        ival_max = 7'd126;
        apply_cfg();
        send_frame(FORM_REPEAT, 0, '0, 1'b0);
        send_frame(FORM_OTHER, 0, '0, 1'b1);

        // Any nonzero header is data; extra bits, partial frame, full frame
        hdr_min  = 8'd0;
        rep_lo   = 8'd255;
        rep_hi   = 8'd0;
        zero_max = 8'd1;
        one_lim  = 8'd3;
        tmo      = 8'd8;
        ival_max = 7'd126;
        apply_cfg();
        send_frame(FORM_DATA, 40, {$urandom, $urandom}, 1'b0);
        send_frame(FORM_DATA, 12, {$urandom, $urandom}, 1'b1);
        send_frame(FORM_DATA, 32, {$urandom, $urandom}, 1'b0);

        // Long result stall while repeat codes keep coming
        pick_profile();
        ival_max = 7'd126;
        apply_cfg();
        hold_req <= 1'b1;
        repeat (8) send_frame(FORM_REPEAT, 0, '0, 1'b0);

        // Random timings, mostly well-formed frames
        while (sent_items < 1550 || good_frames < 36) begin
            pick_profile();
            apply_cfg();
            repeat (6) send_mixed();
        end

        drain();
        if (pending != 0)
            $display("%0t: %0d predicted results never delivered", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ ir_pulse_distance_decoder.f @@
hw/rtl/irpd_pkg.sv
hw/rtl/irpd_if.sv
hw/rtl/irpd_cfg_regs.sv
hw/rtl/irpd_front.sv
hw/rtl/irpd_queue.sv
hw/rtl/irpd_back.sv
hw/rtl/ir_pulse_distance_decoder.sv
tb/irpd_frame_checker.sv
tb/tb_top.sv
